>>> sv/sorted_table_binary_search_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table search core
// Clocked assertions on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define STS_ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STS_ASSERT(lbl, prop, msg) \
  `STS_ASSERT_CLKRST(lbl, clk_i, rst_ni, prop, msg)
`else
`define STS_ASSERT_CLKRST(lbl, clk, rst_n, prop, msg)
`define STS_ASSERT(lbl, prop, msg)
`endif

`endif

>>> sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sorted table search core.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  localparam int unsigned LEN_W   = 11;
  localparam int unsigned EIDX_W  = 10;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned MATCH_W = 10;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic [MODE_W-1:0] MODE_ANY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LAST  = 2'd2;

  typedef struct packed {
    logic                      action;
    logic [EIDX_W-1:0]         entry_index;
    logic signed [FIELD_W-1:0] entry_value;
    logic signed [FIELD_W-1:0] search_key;
    logic [MODE_W-1:0]         occurrence_mode;
  } sts_in_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] match_index;
  } sts_out_t;

  typedef struct packed {
    logic hit;   // probe matched the key
    logic stop;  // search ends after this step
  } sts_probe_flags_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } sts_ctrl_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_DONE
  } sts_state_e;

endpackage

>>> sv/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core: binary search over a loaded sorted table
// Write transfer: the input stays ready and the block does not go busy. Search
// transfer: a start step, then P probes at one table read per cycle, then the
// result valid in the done state; P <= floor(log2(length)) + 1.
// Input ready returns once the result is in the output register.
// Reset clears length and control; table contents are undefined until written.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_core_assert.svh"

module sorted_table_binary_search_core import sts_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sts_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sts_out_t         out_data_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [LEN_W-1:0] table_length_q;
  logic [CNT_W-1:0] len_clamped;

  logic in_xfer, wr_en, start;
  logic rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic signed [VALUE_BITS-1:0] rd_data;

  sts_ctrl_stat_t stat;
  sts_out_t       res;
  logic           res_ready;

  logic     out_valid_q, out_valid_d;
  sts_out_t out_data_q, out_data_d;

  // length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
    end else if (cfg_valid_i) begin
      table_length_q <= cfg_data_i;
    end
  end

  assign len_clamped = (32'(table_length_q) > 32'(TABLE_DEPTH)) ?
                       CNT_W'(TABLE_DEPTH) : CNT_W'(table_length_q);

  // input decode
  assign in_ready_o = stat.idle;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign wr_en      = in_xfer && (in_data_i.action == ACT_WRITE) &&
                      (32'(in_data_i.entry_index) < 32'(TABLE_DEPTH));
  assign start      = in_xfer && (in_data_i.action == ACT_SEARCH);

  sts_table_ram #(
    .VALUE_BITS  (VALUE_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (IDX_W'(in_data_i.entry_index)),
    .wr_data_i (VALUE_BITS'(in_data_i.entry_value)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sts_search_ctrl #(
    .VALUE_BITS  (VALUE_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .len_i       (len_clamped),
    .key_i       (VALUE_BITS'(in_data_i.search_key)),
    .mode_i      (in_data_i.occurrence_mode),
    .rd_data_i   (rd_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .res_ready_i (res_ready),
    .stat_o      (stat),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (stat.res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `STS_ASSERT(a_search_goes_busy, start |=> !in_ready_o, "search left the block idle")
  `STS_ASSERT(a_write_stays_idle, (in_xfer && !start) |=> in_ready_o, "write left block busy")
  `STS_ASSERT(a_miss_index_zero, (out_valid_o && !out_data_o.found) |-> (out_data_o.match_index == '0), "miss index")

endmodule

>>> sv/sts_table_ram.sv
// ----------------------------------------------------------------------------
// sts_table_ram
// Value table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sts_table_ram import sts_pkg::*; #(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [IDX_W-1:0]             wr_addr_i,
  input  logic signed [VALUE_BITS-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [IDX_W-1:0]             rd_addr_i,
  output logic signed [VALUE_BITS-1:0] rd_data_o
);

  logic signed [VALUE_BITS-1:0] mem [TABLE_DEPTH];
  logic signed [VALUE_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/sts_probe_unit.sv
// ----------------------------------------------------------------------------
// sts_probe_unit
// One binary search step: compare the probed entry, narrow the range and
// form the next floor midpoint. Range is half open, [lo, hi).
// ----------------------------------------------------------------------------
module sts_probe_unit import sts_pkg::*; #(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                         cmp_en_i,
  input  logic [CNT_W-1:0]             lo_i,
  input  logic [CNT_W-1:0]             hi_i,
  input  logic [IDX_W-1:0]             mid_i,
  input  logic signed [VALUE_BITS-1:0] rd_data_i,
  input  logic signed [VALUE_BITS-1:0] key_i,
  input  logic [MODE_W-1:0]            mode_i,
  output logic [CNT_W-1:0]             lo_o,
  output logic [CNT_W-1:0]             hi_o,
  output logic [IDX_W-1:0]             mid_o,
  output sts_probe_flags_t             flags_o
);

  logic             stop_hit;
  logic [CNT_W-1:0] mid_ext;
  logic [CNT_W-1:0] span;

  assign mid_ext = CNT_W'(mid_i);

  always_comb begin
    lo_o     = lo_i;
    hi_o     = hi_i;
    stop_hit = 1'b0;
    flags_o.hit = 1'b0;
    if (cmp_en_i) begin
      if (rd_data_i == key_i) begin
        flags_o.hit = 1'b1;
        case (mode_i)
          MODE_FIRST: hi_o = mid_ext;
          MODE_LAST:  lo_o = mid_ext + 1'b1;
          default:    stop_hit = 1'b1;  // any match, unused code too
        endcase
      end else if (rd_data_i > key_i) begin
        hi_o = mid_ext;
      end else begin
        lo_o = mid_ext + 1'b1;
      end
    end
    flags_o.stop = stop_hit || (lo_o >= hi_o);
  end

  // only meaningful while the range is non-empty
  assign span  = hi_o - lo_o - 1'b1;
  assign mid_o = IDX_W'(lo_o + (span >> 1));

endmodule

>>> sv/sts_search_ctrl.sv
// ----------------------------------------------------------------------------
// sts_search_ctrl
// Search sequencer: holds the range, drives table reads and reuses the probe
// unit once per cycle until the range closes or, in any-match mode, a probe hits.
// ----------------------------------------------------------------------------
module sts_search_ctrl import sts_pkg::*; #(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [CNT_W-1:0]             len_i,
  input  logic signed [VALUE_BITS-1:0] key_i,
  input  logic [MODE_W-1:0]            mode_i,
  input  logic signed [VALUE_BITS-1:0] rd_data_i,
  output logic                         rd_en_o,
  output logic [IDX_W-1:0]             rd_addr_o,
  input  logic                         res_ready_i,
  output sts_ctrl_stat_t               stat_o,
  output sts_out_t                     res_o
);

  sts_state_e state_q, state_d;

  logic [CNT_W-1:0]             lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]             mid_q, mid_d, ans_q, ans_d;
  logic signed [VALUE_BITS-1:0] key_q, key_d;
  logic [MODE_W-1:0]            mode_q, mode_d;
  logic                         hit_q, hit_d;

  logic [CNT_W-1:0]  lo_n, hi_n;
  logic [IDX_W-1:0]  mid_n;
  logic              cmp_en;
  sts_probe_flags_t  flags;

  assign cmp_en = (state_q == ST_PROBE);

  sts_probe_unit #(
    .VALUE_BITS  (VALUE_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_probe (
    .cmp_en_i  (cmp_en),
    .lo_i      (lo_q),
    .hi_i      (hi_q),
    .mid_i     (mid_q),
    .rd_data_i (rd_data_i),
    .key_i     (key_q),
    .mode_i    (mode_q),
    .lo_o      (lo_n),
    .hi_o      (hi_n),
    .mid_o     (mid_n),
    .flags_o   (flags)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_START;
      end
      ST_START, ST_PROBE: begin
        if (flags.stop) state_d = ST_DONE;
        else            state_d = ST_PROBE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rd_en_o          = 1'b0;
    rd_addr_o        = mid_n;
    stat_o.idle      = 1'b0;
    stat_o.res_valid = 1'b0;
    unique case (state_q)
      ST_IDLE:            stat_o.idle = 1'b1;
      ST_START, ST_PROBE: rd_en_o = !flags.stop;
      ST_DONE:            stat_o.res_valid = 1'b1;
      default:            stat_o.idle = 1'b0;
    endcase
  end

  assign res_o.found       = hit_q;
  assign res_o.match_index = hit_q ? MATCH_W'(ans_q) : '0;

  // datapath
  always_comb begin
    lo_d   = lo_q;
    hi_d   = hi_q;
    mid_d  = mid_q;
    key_d  = key_q;
    mode_d = mode_q;
    hit_d  = hit_q;
    ans_d  = ans_q;
    if (state_q == ST_IDLE && start_i) begin
      lo_d   = '0;
      hi_d   = len_i;
      key_d  = key_i;
      mode_d = mode_i;
      hit_d  = 1'b0;
      ans_d  = '0;
    end else if (state_q == ST_START || state_q == ST_PROBE) begin
      lo_d  = lo_n;
      hi_d  = hi_n;
      mid_d = mid_n;
      if (flags.hit) begin
        hit_d = 1'b1;
        ans_d = mid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    key_q  <= key_d;
    mode_q <= mode_d;
    ans_q  <= ans_d;
  end

endmodule
